[sv/edd_pkg.sv]
// Shared constants, codes and step tables for the error diffusion dither.
// No dependencies; design files use scoped names, bench files import it.
package edd_pkg;

  localparam int GRAY_W     = 8;
  localparam int ERR_W      = 9;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int LEVEL_W    = 4;
  localparam int ROW_W      = 12;
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int STEP_W     = 9;
  localparam int RECIP_W    = 17;
  localparam int RECIP_SH   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LEVELS = 2'd2
  } cfg_idx_e;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [2:0] W_RIGHT      = 3'd7;
  localparam logic [2:0] W_DOWN_LEFT  = 3'd3;
  localparam logic [2:0] W_DOWN       = 3'd5;
  localparam logic [2:0] W_DOWN_RIGHT = 3'd1;

  function automatic logic [LEVEL_W-1:0] eff_levels(logic [LEVEL_W-1:0] b);
    logic [LEVEL_W-1:0] r;
    r = b;
    if (b == '0) r = 4'd1;
    else if (b > 4'd8) r = 4'd8;
    return r;
  endfunction

  // quantizer step 256 / (2^b - 1)
  function automatic logic [STEP_W-1:0] step_size(logic [LEVEL_W-1:0] b);
    logic [STEP_W-1:0] k;
    case (b)
      4'd1:    k = 9'd256;
      4'd2:    k = 9'd85;
      4'd3:    k = 9'd36;
      4'd4:    k = 9'd17;
      4'd5:    k = 9'd8;
      4'd6:    k = 9'd4;
      4'd7:    k = 9'd2;
      default: k = 9'd1;
    endcase
    return k;
  endfunction

  // floor(2^16 / step)
  function automatic logic [RECIP_W-1:0] step_recip(logic [LEVEL_W-1:0] b);
    logic [RECIP_W-1:0] m;
    case (b)
      4'd1:    m = 17'd256;
      4'd2:    m = 17'd771;
      4'd3:    m = 17'd1820;
      4'd4:    m = 17'd3855;
      4'd5:    m = 17'd8192;
      4'd6:    m = 17'd16384;
      4'd7:    m = 17'd32768;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

[sv/edd_if.sv]
// Handshake channels of the dither: pixel requests, results and register writes.
// Depends on edd_pkg for field widths.
interface edd_pix_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [edd_pkg::GRAY_W-1:0]   gray_in;
  modport source (output valid, kind, gray_in, input ready);
  modport sink (input valid, kind, gray_in, output ready);
endinterface

interface edd_res_if;
  logic                         valid;
  logic                         ready;
  logic [edd_pkg::GRAY_W-1:0]   gray_out;
  logic                         frame_end;
  modport source (output valid, gray_out, frame_end, input ready);
  modport sink (input valid, gray_out, frame_end, output ready);
endinterface

interface edd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [edd_pkg::CFG_IDX_W-1:0]    index;
  logic [edd_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/edd_line_store.sv]
// Two-row line store: one write port, one read port with registered data.
// Depends on edd_pkg for the pixel width.
module edd_line_store #(
  parameter int AW = 11
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [edd_pkg::GRAY_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [edd_pkg::GRAY_W-1:0] rdata_o
);

  logic [edd_pkg::GRAY_W-1:0] mem_q [2**AW];
  logic [edd_pkg::GRAY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/edd_quantizer.sv]
// Three-stage quantizer: round half up to a multiple of the level step, clamp, error.
// Uses a reciprocal multiply with one correction step; depends on edd_pkg tables.
module edd_quantizer (
  input  logic                              clk_i,
  input  logic [edd_pkg::GRAY_W-1:0]        old_i,
  input  logic [edd_pkg::LEVEL_W-1:0]       levels_i,
  output logic [edd_pkg::GRAY_W-1:0]        nw_o,
  output logic signed [edd_pkg::ERR_W-1:0]  err_o
);

  logic [edd_pkg::STEP_W-1:0]  k_s;
  logic [edd_pkg::RECIP_W-1:0] m_s;
  logic [8:0]                  n_s;
  logic [25:0]                 prod_s;

  logic [8:0]                  n1_q, k1_q;
  logic [7:0]                  old1_q;
  logic [25:0]                 prod1_q;

  logic [8:0]                  qest_s;
  logic [17:0]                 mul2_s;
  logic [8:0]                  n2_q, k2_q, r2_q;
  logic [7:0]                  old2_q;

  logic [8:0]                  rem_s;
  logic [9:0]                  mult_s;
  logic [7:0]                  nw_s;
  logic [7:0]                  nw_q;
  logic signed [8:0]           err_q;

  always_comb begin
    k_s    = edd_pkg::step_size(levels_i);
    m_s    = edd_pkg::step_recip(levels_i);
    n_s    = {1'b0, old_i} + {1'b0, k_s[8:1]};
    prod_s = 26'(n_s) * 26'(m_s);
  end

  always_comb begin
    qest_s = prod1_q[edd_pkg::RECIP_SH +: 9];
    mul2_s = qest_s * k1_q;
  end

  always_comb begin
    rem_s  = n2_q - r2_q;
    mult_s = (rem_s >= k2_q) ? ({1'b0, r2_q} + {1'b0, k2_q}) : {1'b0, r2_q};
    nw_s   = (mult_s > 10'd255) ? 8'd255 : mult_s[7:0];
  end

  always_ff @(posedge clk_i) begin
    n1_q    <= n_s;
    k1_q    <= k_s;
    old1_q  <= old_i;
    prod1_q <= prod_s;
    n2_q    <= n1_q;
    k2_q    <= k1_q;
    old2_q  <= old1_q;
    r2_q    <= mul2_s[8:0];
    nw_q    <= nw_s;
    err_q   <= $signed({1'b0, old2_q}) - $signed({1'b0, nw_s});
  end

  assign nw_o  = nw_q;
  assign err_o = err_q;

endmodule

[sv/edd_share_unit.sv]
// Shared error share unit: floor((16*p + w*e) / 16) clamped to 0..255.
// Depends on edd_pkg for widths.
module edd_share_unit (
  input  logic [edd_pkg::GRAY_W-1:0]        pix_i,
  input  logic signed [edd_pkg::ERR_W-1:0]  err_i,
  input  logic [2:0]                        weight_i,
  output logic [edd_pkg::GRAY_W-1:0]        share_o
);

  logic signed [12:0] prod_s;
  logic signed [13:0] sum_s;

  always_comb begin
    prod_s  = $signed({1'b0, weight_i}) * err_i;
    sum_s   = $signed({2'b00, pix_i, 4'b0000}) + {prod_s[12], prod_s};
    share_o = sum_s[11:4];
    if (sum_s[13]) share_o = '0;
    else if (sum_s > 14'sd4080) share_o = 8'd255;
  end

endmodule

[sv/error_diffusion_dither.sv]
// Floyd-Steinberg error diffusion dither of 8-bit gray pixels, top level.
// Uses edd_pkg, edd_if, edd_line_store, edd_quantizer and edd_share_unit.
//
// Channels: pix_i takes requests (kind 0 = raw pixel in raster order, kind 1 =
// flush one pixel of the last row); res_o returns quantized pixels in raster
// order, frame_end marking the final flushed pixel; cfg_i writes width,
// height and level bits, and is always ready.
// A raw pixel of the first row is only stored and yields no result. A raw
// pixel of a later row releases the pixel above it through the steps READ,
// Q0, Q1, Q2, SH7, SH3, SH5 and EMIT; a flush request skips SH3 and SH5.
// Requests are taken only while idle; ignored ones are simply dropped. The
// sequencer steps the line store through three reads, up to three writes and
// the 3-stage quantizer, with one share unit doing all four error shares.
// Reset clears position, error and output state; registers return to 1024
// pixels, 480 rows and 1 level bit. Line store contents are undefined.
// A stalled receiver holds the result register; the next request is still
// taken and the block waits only when it has a new result to place.
module error_diffusion_dither #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  edd_pix_if.sink        pix_i,
  edd_res_if.source      res_o,
  edd_cfg_if.sink        cfg_i
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = XW + 1;
  localparam int HW = edd_pkg::HEIGHT_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_READ = 4'd1;
  localparam logic [3:0] ST_Q0   = 4'd2;
  localparam logic [3:0] ST_Q1   = 4'd3;
  localparam logic [3:0] ST_Q2   = 4'd4;
  localparam logic [3:0] ST_SH7  = 4'd5;
  localparam logic [3:0] ST_SH3  = 4'd6;
  localparam logic [3:0] ST_SH5  = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  logic [3:0] state_q, state_d;

  logic [edd_pkg::WIDTH_W-1:0]  width_q;
  logic [edd_pkg::HEIGHT_W-1:0] height_q;
  logic [edd_pkg::LEVEL_W-1:0]  levels_q;

  logic [XW-1:0]                    in_col_q, out_col_q;
  logic [edd_pkg::ROW_W-1:0]        in_row_q;
  logic                             flushing_q;
  logic                             flush_mode_q;
  logic signed [edd_pkg::ERR_W-1:0] pend_q;

  logic [7:0]                       gray_q, v1_q, right_q, left_q, nw_q;
  logic signed [edd_pkg::ERR_W-1:0] err_q;

  logic       out_valid_q;
  logic [7:0] out_gray_q;
  logic       out_end_q;

  logic [CW-1:0]               w_eff;
  logic [HW-1:0]               h_eff;
  logic [edd_pkg::LEVEL_W-1:0] lev_eff;
  logic                        in_last, out_last, col_last, row_last;
  logic [XW-1:0]               col, col_next, col_prev;
  logic                        par_a, par_b;
  logic                        accept, load, adv_raw, adv_flush;

  logic                             mem_we;
  logic [AW-1:0]                    waddr, raddr;
  logic [7:0]                       wdata, rdata;
  logic [7:0]                       sh_pix, sh_res;
  logic signed [edd_pkg::ERR_W-1:0] sh_err;
  logic [2:0]                       sh_weight;
  logic [7:0]                       q_nw;
  logic signed [edd_pkg::ERR_W-1:0] q_err;

  always_comb begin
    if (width_q == '0) w_eff = CW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_q);
    if (height_q == '0) h_eff = HW'(1);
    else if (32'(height_q) > edd_pkg::MAX_HEIGHT) h_eff = HW'(edd_pkg::MAX_HEIGHT);
    else h_eff = height_q;
    lev_eff  = edd_pkg::eff_levels(levels_q);
    in_last  = (CW'(in_col_q) + CW'(1)) >= w_eff;
    out_last = (CW'(out_col_q) + CW'(1)) >= w_eff;
    row_last = (HW'(in_row_q) + HW'(1)) >= h_eff;
    col      = flush_mode_q ? out_col_q : in_col_q;
    col_last = flush_mode_q ? out_last : in_last;
    col_next = col + XW'(1);
    col_prev = col - XW'(1);
    par_a    = flush_mode_q ? in_row_q[0] : ~in_row_q[0];
    par_b    = in_row_q[0];
  end

  assign pix_i.ready = (state_q == ST_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    state_d   = state_q;
    adv_raw   = 1'b0;
    adv_flush = 1'b0;
    load      = 1'b0;
    mem_we    = 1'b0;
    waddr     = {par_b, col};
    wdata     = sh_res;
    raddr     = {par_a, col};
    sh_pix    = gray_q;
    sh_err    = pend_q;
    sh_weight = edd_pkg::W_DOWN_RIGHT;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (pix_i.kind == edd_pkg::KIND_FLUSH) begin
            if (flushing_q) state_d = ST_READ;
          end else if (!flushing_q) begin
            if (in_row_q == '0) begin
              mem_we  = 1'b1;
              waddr   = {in_row_q[0], in_col_q};
              wdata   = pix_i.gray_in;
              adv_raw = 1'b1;
            end else begin
              state_d = ST_READ;
            end
          end
        end
      end
      ST_READ: state_d = ST_Q0;
      ST_Q0: begin
        raddr   = {par_a, col_next};
        state_d = ST_Q1;
      end
      ST_Q1: begin
        raddr   = {par_b, col_prev};
        state_d = ST_Q2;
      end
      ST_Q2: state_d = ST_SH7;
      ST_SH7: begin
        sh_pix    = right_q;
        sh_err    = q_err;
        sh_weight = edd_pkg::W_RIGHT;
        mem_we    = !col_last;
        waddr     = {par_a, col_next};
        state_d   = flush_mode_q ? ST_EMIT : ST_SH3;
      end
      ST_SH3: begin
        sh_pix    = left_q;
        sh_err    = err_q;
        sh_weight = edd_pkg::W_DOWN_LEFT;
        mem_we    = (col != '0);
        waddr     = {par_b, col_prev};
        state_d   = ST_SH5;
      end
      ST_SH5: begin
        sh_pix    = v1_q;
        sh_err    = err_q;
        sh_weight = edd_pkg::W_DOWN;
        mem_we    = 1'b1;
        waddr     = {par_b, col};
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          load      = 1'b1;
          adv_raw   = !flush_mode_q;
          adv_flush = flush_mode_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  edd_line_store #(.AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  edd_quantizer u_quant (
    .clk_i    (clk_i),
    .old_i    (rdata),
    .levels_i (lev_eff),
    .nw_o     (q_nw),
    .err_o    (q_err)
  );

  edd_share_unit u_share (
    .pix_i    (sh_pix),
    .err_i    (sh_err),
    .weight_i (sh_weight),
    .share_o  (sh_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      width_q      <= 11'd1024;
      height_q     <= 13'd480;
      levels_q     <= 4'd1;
      in_col_q     <= '0;
      out_col_q    <= '0;
      in_row_q     <= '0;
      flushing_q   <= 1'b0;
      flush_mode_q <= 1'b0;
      pend_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          edd_pkg::CFG_WIDTH:  width_q  <= cfg_i.data[edd_pkg::WIDTH_W-1:0];
          edd_pkg::CFG_HEIGHT: height_q <= cfg_i.data[edd_pkg::HEIGHT_W-1:0];
          edd_pkg::CFG_LEVELS: levels_q <= cfg_i.data[edd_pkg::LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        flush_mode_q <= (pix_i.kind == edd_pkg::KIND_FLUSH);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (adv_raw) begin
        if (in_last) begin
          in_col_q <= '0;
          pend_q   <= '0;
          if (row_last) begin
            flushing_q <= 1'b1;
            out_col_q  <= '0;
          end else begin
            in_row_q <= in_row_q + 1'b1;
          end
        end else begin
          in_col_q <= in_col_q + XW'(1);
          if (in_row_q != '0) pend_q <= err_q;
        end
      end
      if (adv_flush) begin
        if (out_last) begin
          in_row_q   <= '0;
          in_col_q   <= '0;
          out_col_q  <= '0;
          flushing_q <= 1'b0;
          pend_q     <= '0;
        end else begin
          out_col_q <= out_col_q + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) gray_q <= pix_i.gray_in;
    if (state_q == ST_READ) v1_q <= (in_col_q == '0) ? gray_q : sh_res;
    if (state_q == ST_Q1) right_q <= rdata;
    if (state_q == ST_Q2) left_q <= rdata;
    if (state_q == ST_SH7) begin
      err_q <= q_err;
      nw_q  <= q_nw;
    end
    if (load) begin
      out_gray_q <= nw_q;
      out_end_q  <= flush_mode_q && col_last;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.gray_out  = out_gray_q;
  assign res_o.frame_end = out_end_q;

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result loaded outside the emit step");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ || state_q == ST_Q0 || state_q == ST_Q1 || state_q == ST_Q2)
      |-> !mem_we)
    else $error("line store written during a read step");

  a_flush_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> (in_col_q == '0))
    else $error("raw column advanced while flushing");

  a_pend_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_col_q == '0) |-> (pend_q == '0))
    else $error("held error not cleared at row start");

  a_out_col_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flushing_q |-> (out_col_q == '0))
    else $error("flush column moved outside a flush");

endmodule

[bench/edd_checker.sv]
`timescale 1ns / 1ps
// Checker for the error diffusion dither: watches the pixel, result and register channels.
// Keeps its own copy of the line store and position to predict each quantized pixel.
// Depends on edd_pkg and the channel interfaces in edd_if.
module edd_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  edd_pix_if   pix,
  edd_res_if   res,
  edd_cfg_if   cfg,
  output int   fail_count_o,
  output int   awaited_o,
  output int   result_count_o
);
  import edd_pkg::*;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic              frame_end;
  } dither_out_t;

  dither_out_t quantized_q[$];

  logic [GRAY_W-1:0]   line_mem [2*MAX_WIDTH];
  int                  carry_err;
  int                  next_col;
  int                  next_row;
  int                  flush_col;
  bit                  draining;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [LEVEL_W-1:0]  level_reg;

  function automatic int cell_of(int row, int col);
    return (row % 2) * MAX_WIDTH + ((col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col);
  endfunction

  function automatic logic [GRAY_W-1:0] level_of(logic [GRAY_W-1:0] v);
    int b;
    int k;
    int q;
    b = (level_reg == '0) ? 1 : (level_reg > 4'd8) ? 8 : int'(level_reg);
    k = 256 / ((1 << b) - 1);
    q = (2 * int'(v) + k) / (2 * k) * k;
    return (q > 255) ? '1 : GRAY_W'(q);
  endfunction

  function automatic logic [GRAY_W-1:0] spread(logic [GRAY_W-1:0] p, int err,
                                                logic [2:0] wgt);
    int t;
    t = 16 * int'(p) + int'(wgt) * err;
    if (t < 0) begin
      return '0;
    end
    if (t > 4080) begin
      return '1;
    end
    return GRAY_W'(t >>> 4);
  endfunction

  task automatic diffuse_request(logic kind, logic [GRAY_W-1:0] gray_in);
    int w;
    int h;
    int x;
    int r;
    int err;
    logic [GRAY_W-1:0] v;
    logic [GRAY_W-1:0] old_v;
    logic [GRAY_W-1:0] new_v;
    dither_out_t outcome;
    w = (width_reg == '0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    h = (height_reg == '0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    if (kind == KIND_FLUSH) begin
      if (draining) begin
        x = flush_col;
        r = next_row;
        old_v = line_mem[cell_of(r, x)];
        new_v = level_of(old_v);
        err = int'(old_v) - int'(new_v);
        if (x + 1 < w) begin
          line_mem[cell_of(r, x + 1)] = spread(line_mem[cell_of(r, x + 1)], err, W_RIGHT);
        end
        outcome.gray = new_v;
        outcome.frame_end = (x + 1 >= w);
        quantized_q.push_back(outcome);
        if (x + 1 >= w) begin
          next_row = 0;
          next_col = 0;
          flush_col = 0;
          draining = 1'b0;
          carry_err = 0;
        end else begin
          flush_col = x + 1;
        end
      end
    end else if (!draining) begin
      x = next_col;
      r = next_row;
      v = gray_in;
      if (r == 0) begin
        line_mem[cell_of(r, x)] = v;
      end else begin
        if (x > 0) begin
          v = spread(v, carry_err, W_DOWN_RIGHT);
        end
        line_mem[cell_of(r, x)] = v;
        old_v = line_mem[cell_of(r - 1, x)];
        new_v = level_of(old_v);
        err = int'(old_v) - int'(new_v);
        if (x + 1 < w) begin
          line_mem[cell_of(r - 1, x + 1)] =
            spread(line_mem[cell_of(r - 1, x + 1)], err, W_RIGHT);
        end
        if (x > 0) begin
          line_mem[cell_of(r, x - 1)] = spread(line_mem[cell_of(r, x - 1)], err, W_DOWN_LEFT);
        end
        line_mem[cell_of(r, x)] = spread(line_mem[cell_of(r, x)], err, W_DOWN);
        carry_err = (x + 1 < w) ? err : 0;
        outcome.gray = new_v;
        outcome.frame_end = 1'b0;
        quantized_q.push_back(outcome);
      end
      if (x + 1 >= w) begin
        next_col = 0;
        carry_err = 0;
        if (r + 1 >= h) begin
          draining = 1'b1;
          flush_col = 0;
        end else begin
          next_row = r + 1;
        end
      end else begin
        next_col = x + 1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dither_out_t want;
    if (!rst_ni) begin
      quantized_q.delete();
      carry_err = 0;
      next_col = 0;
      next_row = 0;
      flush_col = 0;
      draining = 1'b0;
      width_reg = WIDTH_W'(1024);
      height_reg = HEIGHT_W'(480);
      level_reg = LEVEL_W'(1);
      fail_count_o = 0;
      result_count_o = 0;
      awaited_o = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_e'(cfg.index))
          CFG_WIDTH: width_reg = cfg.data[WIDTH_W-1:0];
          CFG_HEIGHT: height_reg = cfg.data[HEIGHT_W-1:0];
          CFG_LEVELS: level_reg = cfg.data[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        diffuse_request(pix.kind, pix.gray_in);
      end
      if (res.valid && res.ready) begin
        result_count_o++;
        if (quantized_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with none awaited: expected nothing, actual gray_out %0d frame_end %0b",
                   $time, res.gray_out, res.frame_end);
        end else begin
          want = quantized_q.pop_front();
          if (res.gray_out !== want.gray) begin
            fail_count_o++;
            $display("%0t: gray_out expected %0d actual %0d", $time, want.gray, res.gray_out);
          end
          if (res.frame_end !== want.frame_end) begin
            fail_count_o++;
            $display("%0t: frame_end expected %0b actual %0b", $time, want.frame_end,
                     res.frame_end);
          end
        end
      end
      awaited_o = quantized_q.size();
    end
  end

endmodule

[bench/tb_error_diffusion_dither.sv]
`timescale 1ns / 1ps
// Top of the error diffusion dither bench: clock, reset, register writes and pixel requests.
// Directed corners, extreme frame sizes, then random frames with noise and mid-frame reshapes.
// Depends on edd_pkg, edd_if, error_diffusion_dither and edd_checker.
module tb_error_diffusion_dither;
  import edd_pkg::*;

  localparam int MAX_WIDTH     = 1024;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int RANDOM_ITEMS  = 900;
  localparam int IDLE_PCT      = 23;
  localparam int NOISE_PCT     = 8;
  localparam int SETTLE_CYCLES = 20;
  localparam logic [GRAY_W-1:0] CORNER_PX [6] = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd127};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   sender_idle_pct    = IDLE_PCT;
  int   receiver_stall_pct = IDLE_PCT;
  int   cycle_count = 0;
  int   sent_count  = 0;
  int   frame_count = 0;
  int   frame_w = 1;
  int   frame_h = 1;
  int   fail_count;
  int   awaited;
  int   result_count;

  edd_pix_if pix ();
  edd_res_if res ();
  edd_cfg_if cfg ();

  error_diffusion_dither #(.MAX_WIDTH(MAX_WIDTH)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .res_o (res),
    .cfg_i (cfg)
  );

  edd_checker #(.MAX_WIDTH(MAX_WIDTH)) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix           (pix),
    .res           (res),
    .cfg           (cfg),
    .fail_count_o  (fail_count),
    .awaited_o     (awaited),
    .result_count_o(result_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res.ready <= rst_ni && ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [GRAY_W-1:0] pick_gray();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) begin
      return '0;
    end
    if (sel == 1) begin
      return '1;
    end
    return GRAY_W'($urandom);
  endfunction

  task automatic push_request(input logic kind, input logic [GRAY_W-1:0] gray);
    while ($urandom_range(99) < sender_idle_pct) begin
      pix.valid <= 1'b0;
      pix.kind <= 1'($urandom_range(1));
      pix.gray_in <= GRAY_W'($urandom);
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.kind <= kind;
    pix.gray_in <= gray;
    do @(posedge clk_i); while (!pix.ready);
    sent_count++;
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    do @(posedge clk_i); while (awaited != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input int value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg.ready);
  endtask

  task automatic write_setup(input int width, input int height, input int bits);
    drain();
    put_reg(CFG_WIDTH, width);
    put_reg(CFG_HEIGHT, height);
    put_reg(CFG_LEVELS, bits);
    cfg.valid <= 1'b0;
    frame_w = (width == 0) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH : width;
    frame_h = (height == 0) ? 1 : (height > MAX_HEIGHT) ? MAX_HEIGHT : height;
  endtask

  task automatic run_frame(input int noise_pct, input bit reshape);
    int row;
    int col;
    int rows;
    int cols;
    int stop_row;
    int stop_col;
    rows = frame_h;
    cols = frame_w;
    row = 0;
    col = 0;
    stop_row = $urandom_range(rows - 1, 0);
    stop_col = $urandom_range(cols - 1, 0);
    if (stop_row == 0 && stop_col == 0) begin
      reshape = 1'b0;
    end
    while (row < rows) begin
      if (reshape && row == stop_row && col == stop_col) begin
        reshape = 1'b0;
        write_setup((col == 0) ? $urandom_range(cols, 1) : $urandom_range(col + 1, 1),
                    $urandom_range(rows + 2, 1), $urandom_range(15));
        cols = frame_w;
        rows = (frame_h > row + 1) ? frame_h : row + 1;
      end
      if ($urandom_range(99) < noise_pct) begin
        push_request(KIND_FLUSH, pick_gray());
      end
      push_request(KIND_PIXEL, pick_gray());
      col++;
      if (col >= cols) begin
        col = 0;
        row++;
      end
    end
    col = 0;
    while (col < cols) begin
      if ($urandom_range(99) < noise_pct) begin
        push_request(KIND_PIXEL, pick_gray());
      end
      push_request(KIND_FLUSH, pick_gray());
      col++;
    end
    if ($urandom_range(99) < noise_pct) begin
      push_request(KIND_FLUSH, pick_gray());
    end
    frame_count++;
  endtask

  initial begin
    int random_base;
    pix.valid = 1'b0;
    pix.kind = KIND_PIXEL;
    pix.gray_in = '0;
    cfg.valid = 1'b0;
    cfg.index = CFG_WIDTH;
    cfg.data = '0;
    res.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of a tiny frame, a stray pixel while flushing, a stray flush after
    write_setup(3, 2, 1);
    foreach (CORNER_PX[i]) begin
      push_request(KIND_PIXEL, CORNER_PX[i]);
    end
    push_request(KIND_PIXEL, 8'd99);
    repeat (3) push_request(KIND_FLUSH, 8'd0);
    push_request(KIND_FLUSH, 8'd255);
    frame_count++;
    write_setup(2, 2, 8);
    run_frame(0, 1'b0);
    write_setup(1, 1, 0);
    run_frame(0, 1'b0);
    write_setup(0, 0, 15);
    run_frame(0, 1'b0);

    // largest frames, one of them with no idling on either side
    write_setup(1024, 2, 4);
    run_frame(0, 1'b0);
    write_setup(2047, 1, 3);
    run_frame(0, 1'b0);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    write_setup(1, 4096, 2);
    run_frame(0, 1'b0);
    sender_idle_pct = IDLE_PCT;
    receiver_stall_pct = IDLE_PCT;
    write_setup(0, 8191, 5);
    run_frame(0, 1'b0);

    random_base = sent_count;
    while (sent_count - random_base < RANDOM_ITEMS) begin
      if (sent_count - random_base >= 300 && sent_count - random_base < 480) begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end else begin
        sender_idle_pct = IDLE_PCT;
        receiver_stall_pct = IDLE_PCT;
      end
      write_setup(($urandom_range(7) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1),
                  $urandom_range(6, 1), $urandom_range(15));
      run_frame(NOISE_PCT, $urandom_range(5) == 0);
    end
    drain();

    $display("Run covered %0d frames and %0d requests, widths 0 to 2047, heights 0 to 8191,",
             frame_count, sent_count);
    $display("level bits 0 to 15, with stray requests and mid-frame reshapes; %0d results checked.",
             result_count);
    if (fail_count == 0 && awaited == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[error_diffusion_dither.f]
sv/edd_pkg.sv
sv/edd_if.sv
sv/edd_line_store.sv
sv/edd_quantizer.sv
sv/edd_share_unit.sv
sv/error_diffusion_dither.sv
bench/edd_checker.sv
bench/tb_error_diffusion_dither.sv
